@@ hw/rtl/ptlm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptlm_pkg
// Shared constants and codes of the periodic task load monitor.
// ----------------------------------------------------------------------------
package ptlm_pkg;

    // Request kinds carried on the input tuser
    localparam int REQ_W = 2;
    localparam logic [REQ_W-1:0] REQ_TIME_CHECK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DURATION   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START      = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_MS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_ENABLED = 1'b1;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int DUR_W   = 31;
    localparam int LOAD_W  = 16;
    localparam int COUNT_W = 8;

    // Beat layouts
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 24;

    // Reset values and limits
    localparam logic [TIME_W-1:0]  PERIOD_RESET    = 32'd1000;
    localparam logic [LOAD_W-1:0]  LOAD_MAX        = 16'hFFFF;
    localparam logic [LOAD_W-1:0]  OVERLOAD_LIMIT  = 16'd100;
    localparam logic [COUNT_W-1:0] OVERLOAD_EVENTS = 8'd5;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'd255;

    // Microseconds to milliseconds, then to percent: 1000 / 100
    localparam int US_PER_MS   = 1000;
    localparam int PERCENT     = 100;
    localparam int LOAD_SCALE  = US_PER_MS / PERCENT;

    localparam int DEFAULT_WINDOW_DEPTH = 8;

endpackage

`default_nettype wire

@@ hw/rtl/ptlm_window.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptlm_window
// Shift window of run durations with a running sum of its entries.
// ----------------------------------------------------------------------------
module ptlm_window #(
    parameter int DEPTH = 8,
    parameter int SUM_W = 35
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      shift_en,
    input  wire logic [ptlm_pkg::DUR_W-1:0] din,
    output logic      [SUM_W-1:0]          sum
);
    import ptlm_pkg::*;

    logic [DUR_W-1:0] win_reg [DEPTH];
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    // Drop the oldest entry, add the new one
    assign sum_next = sum_reg - SUM_W'(win_reg[0]) + SUM_W'(din);
    assign sum      = sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (shift_en)
        begin
            sum_reg <= sum_next;
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[DEPTH-1] <= din;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/ptlm_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ptlm_div
// Restoring divider, one quotient bit per cycle. A zero divisor gives all ones.
// ----------------------------------------------------------------------------
module ptlm_div #(
    parameter int NUM_W = 35,
    parameter int DEN_W = 39
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic                  done,
    output logic      [NUM_W-1:0] quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quot_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    // Shift in the next dividend bit and try to subtract
    assign trial = {rem_reg, quot_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, den_reg});
    assign diff  = trial - {1'b0, den_reg};

    assign done = done_reg;
    assign quot = quot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quot_reg <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                quot_reg <= num;
                rem_reg  <= '0;
                den_reg  <= den;
                cnt_reg  <= CNT_W'(NUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quot_reg <= {quot_reg[NUM_W-2:0], fits};
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/periodic_task_load_monitor_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_task_load_monitor_unit
// Periodic task timer with a windowed run-time load monitor.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: now_ms, duration_us,
//                                              delay_ms; tuser: req_type
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: result flags and load
//  cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
//
//  Time checks, start requests and negative durations go from accept
//  through ST_EXEC and ST_FINISH to the output register. A valid duration
//  report also passes ST_START and ST_DIV: the restoring divider produces one
//  quotient bit per cycle of the window sum over (depth * 10 * period_ms).
//  One beat is in work at a time; a new beat is taken while a finished
//  result still waits on m_axis. After reset the window, sum and counters
//  are clear, period_ms is 1000 and run_enabled is 1. cfg is always ready.
// ----------------------------------------------------------------------------
module periodic_task_load_monitor_unit #(
    parameter int WINDOW_DEPTH = ptlm_pkg::DEFAULT_WINDOW_DEPTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // now_ms [31:0], duration_us [63:32], delay_ms [95:64]
    input  wire logic [ptlm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // req_type [1:0]
    input  wire logic [ptlm_pkg::REQ_W-1:0]         s_axis_tuser,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // run_due [0], first_run [1], load_percent [17:2], load_updated [18],
    // overload_started [19], overload_cleared [20], zero [23:21]
    output logic      [ptlm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ptlm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ptlm_pkg::TIME_W-1:0]        cfg_data
);
    import ptlm_pkg::*;

    // Sum of the window and the divisor depth * 10 * period
    localparam int SUM_W   = DUR_W + $clog2(WINDOW_DEPTH + 1);
    localparam int DEN_MUL = WINDOW_DEPTH * LOAD_SCALE;
    localparam int MUL_W   = $clog2(DEN_MUL + 1);
    localparam int DEN_W   = TIME_W + MUL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_START,
        ST_DIV,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // Configuration
    logic [TIME_W-1:0] period_reg;
    logic              enabled_reg;

    // Captured beat
    logic [REQ_W-1:0]  req_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] dur_reg;
    logic [TIME_W-1:0] delay_reg;

    // Task state
    logic [TIME_W-1:0]  last_run_reg;
    logic               first_pending_reg;
    logic [COUNT_W-1:0] overload_count_reg;
    logic [LOAD_W-1:0]  load_reg;
    logic [DEN_W-1:0]   den_reg;

    // Result flags of the beat in work
    logic res_due_reg;
    logic res_first_reg;
    logic res_updated_reg;
    logic res_started_reg;
    logic res_cleared_reg;

    logic [OUT_DATA_W-1:0] m_data_reg;
    logic                  m_valid_reg;

    logic                  win_shift;
    logic [SUM_W-1:0]      win_sum;
    logic                  div_start;
    logic                  div_done;
    logic [SUM_W-1:0]      div_quot;
    logic [LOAD_W-1:0]     load_sat;
    logic [COUNT_W-1:0]    count_inc;
    logic                  check_fires;
    logic [TIME_W-1:0]     elapsed;
    logic                  out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tvalid = m_valid_reg;

    // Shift the window only for a non-negative duration
    assign win_shift = (state_reg == ST_EXEC) && (req_reg == REQ_DURATION)
                       && !dur_reg[TIME_W-1];
    assign div_start = (state_reg == ST_START);

    // Time check: now not before last run, enabled, and period elapsed
    assign elapsed     = now_reg - last_run_reg;
    assign check_fires = (now_reg >= last_run_reg) && enabled_reg
                         && (elapsed >= period_reg);

    // Clamp the quotient at the load ceiling
    assign load_sat  = (|div_quot[SUM_W-1:LOAD_W]) ? LOAD_MAX : div_quot[LOAD_W-1:0];
    assign count_inc = (overload_count_reg < COUNT_MAX) ? overload_count_reg + 1'b1
                                                        : overload_count_reg;

    // The output register is free when empty or being drained this cycle
    assign out_free = !m_valid_reg || m_axis_tready;

    ptlm_window #(
        .DEPTH (WINDOW_DEPTH),
        .SUM_W (SUM_W)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (win_shift),
        .din      (dur_reg[DUR_W-1:0]),
        .sum      (win_sum)
    );

    ptlm_div #(
        .NUM_W (SUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (win_sum),
        .den   (den_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            period_reg         <= PERIOD_RESET;
            enabled_reg        <= 1'b1;
            req_reg            <= '0;
            now_reg            <= '0;
            dur_reg            <= '0;
            delay_reg          <= '0;
            last_run_reg       <= '0;
            first_pending_reg  <= 1'b1;
            overload_count_reg <= '0;
            load_reg           <= '0;
            den_reg            <= '0;
            res_due_reg        <= 1'b0;
            res_first_reg      <= 1'b0;
            res_updated_reg    <= 1'b0;
            res_started_reg    <= 1'b0;
            res_cleared_reg    <= 1'b0;
            m_data_reg         <= '0;
            m_valid_reg        <= 1'b0;
        end
        else
        begin
            // Configuration writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_PERIOD_MS:   period_reg  <= cfg_data;
                    CFG_RUN_ENABLED: enabled_reg <= cfg_data[0];
                    default:         ;
                endcase
            end

            // Drain the output register unless a new result lands this cycle
            if (m_valid_reg && m_axis_tready && (state_reg != ST_FINISH))
            begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        req_reg         <= s_axis_tuser;
                        now_reg         <= s_axis_tdata[31:0];
                        dur_reg         <= s_axis_tdata[63:32];
                        delay_reg       <= s_axis_tdata[95:64];
                        res_due_reg     <= 1'b0;
                        res_first_reg   <= 1'b0;
                        res_updated_reg <= 1'b0;
                        res_started_reg <= 1'b0;
                        res_cleared_reg <= 1'b0;
                        state_reg       <= ST_EXEC;
                    end
                end

                ST_EXEC:
                begin
                    state_reg <= ST_FINISH;
                    case (req_reg)
                        REQ_TIME_CHECK:
                        begin
                            if (check_fires)
                            begin
                                res_due_reg       <= 1'b1;
                                res_first_reg     <= first_pending_reg;
                                last_run_reg      <= now_reg;
                                first_pending_reg <= 1'b0;
                            end
                        end
                        REQ_DURATION:
                        begin
                            if (dur_reg[TIME_W-1])
                            begin
                                last_run_reg <= '0;
                            end
                            else
                            begin
                                den_reg   <= DEN_W'(period_reg) * DEN_W'(DEN_MUL);
                                state_reg <= ST_START;
                            end
                        end
                        REQ_START:
                        begin
                            last_run_reg <= now_reg + delay_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end

                ST_START:
                begin
                    state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        load_reg        <= load_sat;
                        res_updated_reg <= 1'b1;
                        if (load_sat > OVERLOAD_LIMIT)
                        begin
                            overload_count_reg <= count_inc;
                            res_started_reg    <= (count_inc == OVERLOAD_EVENTS);
                        end
                        else
                        begin
                            res_cleared_reg    <= (overload_count_reg >= OVERLOAD_EVENTS);
                            overload_count_reg <= '0;
                        end
                        state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    // Hold until the output register can take the result
                    if (out_free)
                    begin
                        m_data_reg  <= {3'b000, res_cleared_reg, res_started_reg,
                                        res_updated_reg, load_reg, res_first_reg,
                                        res_due_reg};
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A first-run mark only comes with a firing
    a_first_needs_due: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[1] && !m_axis_tdata[0]))
        else $error("first_run without run_due");

    // A firing and a load update never share a result
    a_due_xor_update: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[18]))
        else $error("run_due and load_updated in one result");

    // The divider finishes only while the sequencer waits on it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside of the divide state");

    // An overload start marks the count reaching its threshold
    a_started_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && res_started_reg)
            |-> (overload_count_reg == OVERLOAD_EVENTS))
        else $error("overload_started with wrong count");

    // A new beat is never taken before the last one is placed in the output
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_EXEC))
        else $error("accepted beat not in work");

endmodule

`default_nettype wire
